>>> rtl/core/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types and constants of the constant fraction discriminator: sum and
// divider widths, status codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package cfd_pkg;

  // Width of one CFD sum: a delayed term times 2^16 minus fraction times a
  // prompt term, both terms 18-bit signed.
  localparam int SUM_W  = 36;
  // Width of a difference of two sums.
  localparam int DIFF_W = SUM_W + 1;
  // Unsigned divider operand width: the denominator stays below 2^35.
  localparam int DIV_W  = SUM_W;
  // Interpolation fraction bits of the crossing time.
  localparam int Q_BITS = 8;
  // Crossing time width and its largest value.
  localparam int TIME_W = 18;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // A denominator below this value has den * 100 under one ADC count (2^20).
  localparam longint GUARD_DEN = ((64'd1 << 20) + 64'd99) / 64'd100;

  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic [DIV_W-1:0]         div_t;
  typedef logic [Q_BITS-1:0]        quo_t;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_ARM  = 2'd1;
  localparam logic [1:0] ST_NO_ZERO = 2'd2;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRACTION  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DELAY     = 2'd2;

  // Register reset values.
  localparam logic [11:0] THRESHOLD_RST = 12'd2600;
  localparam logic [15:0] FRACTION_RST  = 16'd29491;
  localparam logic [5:0]  DELAY_RST     = 6'd11;

endpackage

>>> rtl/core/cfd_div.sv
// ----------------------------------------------------------------------------
// cfd_div
// Restoring divider for the zero-crossing interpolation. It returns
// floor(num * 2^Q_BITS / den) for num < den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cfd_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  cfd_pkg::div_t num,
  input  cfd_pkg::div_t den,
  output logic          done,
  output cfd_pkg::quo_t quo
);

  localparam int CNT_W = $clog2(cfd_pkg::Q_BITS + 1);

  cfd_pkg::div_t          rem;
  cfd_pkg::div_t          den_q;
  logic [CNT_W-1:0]       cnt;
  logic                   busy;
  logic [cfd_pkg::DIV_W:0] rem2;
  logic                   fits;

  // One compare and subtract per quotient bit.
  assign rem2 = {rem, 1'b0};
  assign fits = rem2 >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= num;
        den_q <= den;
        quo   <= '0;
        cnt   <= CNT_W'(cfd_pkg::Q_BITS);
        busy  <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= cfd_pkg::DIV_W'(rem2 - {1'b0, den_q});
        end else begin
          rem <= cfd_pkg::DIV_W'(rem2);
        end
        quo <= {quo[cfd_pkg::Q_BITS-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/constant_fraction_discriminator.sv
// ----------------------------------------------------------------------------
// constant_fraction_discriminator
// Digital CFD for negative-going pulses: arms on two samples under the
// threshold, forms delayed minus attenuated sums over a window, and gives
// one interpolated crossing time with a status on the last sample.
// ----------------------------------------------------------------------------
// A sample beat is taken only in the idle state. The arming sample forms up to
// three window sums and each later sample one, while the window and search are
// open, each through read, multiply and sum steps on the shared multiplier. The
// last sample adds a finish step, the 8-step divider when needed, and any stall.
// Synchronous reset restores the register defaults and clears waveform state;
// the sample history memory needs no clearing.
// ----------------------------------------------------------------------------
module constant_fraction_discriminator #(
  parameter int MAX_DELAY        = 64,
  parameter int ARM_SEARCH_LIMIT = 400,
  parameter int CFD_WINDOW       = 600
) (
  input  logic        clk,
  input  logic        rst,
  // Sample stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [11:0] sample, [27:12] baseline, [31:28] zero
  input  logic        s_tlast,   // last_sample
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [17:0] crossing_time, [23:18] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  // Configuration writes.
  input  logic                            cfg_we,
  input  logic [cfd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [15:0]                     cfg_wdata
);

  localparam int DEPTH = MAX_DELAY + 3;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int AW    = PTR_W + 2;
  localparam int DW    = $clog2(MAX_DELAY + 1);
  localparam int CW    = (DW > 6) ? DW : 6;
  localparam int IDX_W = 16;
  localparam int PSW   = IDX_W + 2;
  localparam int AIW   = $clog2(ARM_SEARCH_LIMIT);
  localparam int TW    = PSW + cfd_pkg::Q_BITS + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_STEP, S_MUL, S_SUM, S_FIN, S_DIV, S_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [11:0] threshold;
  logic [15:0] fraction;
  logic [5:0]  delay_samples;

  // Waveform state.
  logic [IDX_W-1:0] n;
  logic [PTR_W-1:0] wptr;
  logic [IDX_W-1:0] nq;
  logic [PTR_W-1:0] wq;
  logic [AIW-1:0]   arm_index;
  logic             armed;
  logic             found;
  logic             last_q;
  logic [15:0]      held_baseline;
  logic [11:0]      h0, h1, h2;
  logic [1:0]       koff;
  cfd_pkg::sum_t    prev_sum;
  cfd_pkg::sum_t    sum_before;
  cfd_pkg::sum_t    sum_after;
  logic signed [PSW-1:0] cross_base;
  logic [1:0]       status_q;

  // Per-step pipeline registers.
  logic             kd_valid, k_valid, pos_ge1;
  logic [11:0]      rdata;
  logic signed [17:0] wdel_q;
  logic signed [34:0] prod_q;

  // Sample history memory.
  logic [11:0] hist_mem [DEPTH];

  // Input beat fields.
  logic [11:0] in_sample;
  logic [15:0] in_baseline;
  logic        s_accept;
  logic        arm_now;

  assign in_sample   = s_tdata[11:0];
  assign in_baseline = s_tdata[27:12];
  assign s_tready    = (state == S_IDLE);
  assign s_accept    = s_tvalid && s_tready;

  // Arming: this sample and the previous one both under the threshold.
  assign arm_now = !armed && (n != '0) && (n <= IDX_W'(ARM_SEARCH_LIMIT)) &&
                   (h0 < threshold) && (in_sample < threshold);

  // Delay saturated at MAX_DELAY.
  logic [CW-1:0] dly_ext;
  logic [DW-1:0] d_eff;
  assign dly_ext = CW'(delay_samples);
  assign d_eff   = (dly_ext > CW'(MAX_DELAY)) ? DW'(MAX_DELAY) : DW'(dly_ext);

  // Window position of k = nq - koff, relative to start = arm_index - 1.
  logic signed [PSW-1:0] pos;
  logic                  step_active;
  assign pos = $signed(PSW'(nq)) - $signed(PSW'(koff)) - $signed(PSW'(arm_index)) +
               $signed(PSW'(1));
  assign step_active = !found && (pos >= 0) && (pos < CFD_WINDOW);

  // Memory address of k - d, taken modulo the history depth.
  logic [AW-1:0]    raddr_sum;
  logic [PTR_W-1:0] raddr;
  assign raddr_sum = AW'(wq) + AW'(2 * DEPTH) - AW'(koff) - AW'(d_eff);
  always_comb begin
    if (raddr_sum >= AW'(2 * DEPTH)) begin
      raddr = PTR_W'(raddr_sum - AW'(2 * DEPTH));
    end else if (raddr_sum >= AW'(DEPTH)) begin
      raddr = PTR_W'(raddr_sum - AW'(DEPTH));
    end else begin
      raddr = PTR_W'(raddr_sum);
    end
  end

  // Prompt and delayed inverted samples: baseline - 16 * sample.
  logic [11:0]        xk;
  logic signed [17:0] wk, wdel;
  always_comb begin
    case (koff)
      2'd0:    xk = h0;
      2'd1:    xk = h1;
      default: xk = h2;
    endcase
  end
  assign wk   = k_valid ? ($signed({2'b0, held_baseline}) - $signed({2'b0, xk, 4'b0}))
                        : 18'sd0;
  assign wdel = kd_valid ? ($signed({2'b0, held_baseline}) - $signed({2'b0, rdata, 4'b0}))
                         : 18'sd0;

  // CFD sum of the current step.
  cfd_pkg::sum_t s_calc;
  assign s_calc = (cfd_pkg::sum_t'(wdel_q) <<< 16) - cfd_pkg::sum_t'(prod_q);

  // Interpolation operands and the guard on the denominator.
  cfd_pkg::diff_t num_d, den_d;
  logic           div_ok;
  assign num_d  = -cfd_pkg::diff_t'(sum_before);
  assign den_d  = cfd_pkg::diff_t'(sum_after) - cfd_pkg::diff_t'(sum_before);
  assign div_ok = (den_d > 0) && (num_d >= 0) &&
                  (den_d >= cfd_pkg::diff_t'(cfd_pkg::GUARD_DEN));

  // Shared divider.
  logic          div_start, div_done;
  cfd_pkg::quo_t div_quo;
  assign div_start = (state == S_FIN) && armed && found && div_ok;

  cfd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (cfd_pkg::div_t'(num_d)),
    .den   (cfd_pkg::div_t'(den_d)),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Crossing time, clamped to the output range.
  logic signed [TW-1:0]        t_full;
  logic [cfd_pkg::TIME_W-1:0]  t_sat;
  assign t_full = ($signed(TW'(cross_base)) <<< cfd_pkg::Q_BITS) +
                  $signed(TW'(div_quo));
  always_comb begin
    if (t_full < 0) begin
      t_sat = '0;
    end else if (t_full > $signed(TW'(cfd_pkg::TIME_MAX))) begin
      t_sat = cfd_pkg::TIME_MAX;
    end else begin
      t_sat = cfd_pkg::TIME_W'(t_full);
    end
  end

  // State after a finished window step.
  state_t step_next;
  assign step_next = (koff != 2'd0) ? S_STEP : (last_q ? S_FIN : S_IDLE);

  // History memory: write on each sample beat, registered read per step.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      hist_mem[wptr] <= in_sample;
    end
    if (state == S_STEP) begin
      rdata <= hist_mem[raddr];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= cfd_pkg::THRESHOLD_RST;
      fraction      <= cfd_pkg::FRACTION_RST;
      delay_samples <= cfd_pkg::DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        cfd_pkg::REG_THRESHOLD: threshold     <= cfg_wdata[11:0];
        cfd_pkg::REG_FRACTION:  fraction      <= cfg_wdata;
        cfd_pkg::REG_DELAY:     delay_samples <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // Sequencer with registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      n         <= '0;
      wptr      <= '0;
      armed     <= 1'b0;
      found     <= 1'b0;
      arm_index <= '0;
      prev_sum  <= '0;
      koff      <= '0;
      last_q    <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      // A taken result beat drops valid unless a new one is loaded now.
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_accept) begin
            nq     <= n;
            wq     <= wptr;
            last_q <= s_tlast;
            h0     <= in_sample;
            h1     <= h0;
            h2     <= h1;
            if (n == '0) begin
              held_baseline <= in_baseline;
            end
            if (n != '1) begin
              n    <= n + 1'b1;
              wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
            end
            if (arm_now) begin
              armed     <= 1'b1;
              arm_index <= AIW'(n - 1'b1);
              prev_sum  <= '0;
              koff      <= 2'd2;
              state     <= S_STEP;
            end else if (armed) begin
              koff  <= 2'd0;
              state <= S_STEP;
            end else if (s_tlast) begin
              state <= S_FIN;
            end
          end
        end
        S_STEP: begin
          kd_valid <= nq >= (IDX_W'(koff) + IDX_W'(d_eff));
          k_valid  <= nq >= IDX_W'(koff);
          pos_ge1  <= pos >= 1;
          if (step_active) begin
            state <= S_MUL;
          end else begin
            state <= step_next;
            if (koff != 2'd0) begin
              koff <= koff - 1'b1;
            end
          end
        end
        S_MUL: begin
          wdel_q <= wdel;
          prod_q <= $signed({1'b0, fraction}) * wk;
          state  <= S_SUM;
        end
        S_SUM: begin
          if (pos_ge1 && (s_calc > 0)) begin
            found      <= 1'b1;
            sum_before <= prev_sum;
            sum_after  <= s_calc;
            cross_base <= $signed(PSW'(nq)) - $signed(PSW'(koff)) - $signed(PSW'(1));
          end
          prev_sum <= s_calc;
          state    <= step_next;
          if (koff != 2'd0) begin
            koff <= koff - 1'b1;
          end
        end
        S_FIN: begin
          if (!armed) begin
            status_q <= cfd_pkg::ST_NO_ARM;
            state    <= S_OUT;
          end else if (!found || !div_ok) begin
            status_q <= cfd_pkg::ST_NO_ZERO;
            state    <= S_OUT;
          end else begin
            status_q <= cfd_pkg::ST_OK;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= status_q;
            m_tdata  <= {6'b0, (status_q == cfd_pkg::ST_OK) ? t_sat
                                                           : {cfd_pkg::TIME_W{1'b0}}};
            n        <= '0;
            wptr     <= '0;
            armed    <= 1'b0;
            found    <= 1'b0;
            prev_sum <= '0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> verif/constant_fraction_discriminator_test.sv
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// constant_fraction_discriminator_test
// Self-checking bench for the constant fraction discriminator. Sample beats
// go in as short waveforms with random pulses, noise and a few long traces.
// A scoreboard predicts the crossing time and status of every waveform from
// the accepted beats and checks each result beat in order. The register
// settings change between phases, and both streams idle at random.
// ----------------------------------------------------------------------------
module constant_fraction_discriminator_test;

  localparam int     HIST_DEPTH    = 67;
  localparam int     ARM_LIMIT     = 400;
  localparam int     WINDOW_LEN    = 600;
  localparam longint ONE_COUNT     = 64'sd1 << 20;
  localparam int     SETTLE_CYCLES = 32;
  localparam int     QUIET_LIMIT   = 4000;
  localparam int     RANDOM_ITEMS  = 400;
  localparam int     SEGMENTS      = 8;
  // Index that selects no register.
  localparam logic [cfd_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [cfd_pkg::TIME_W-1:0] crossing_time;
    logic [1:0]                 status;
  } crossing_t;

  // Predicts the crossing result of each waveform and checks result beats.
  class crossing_scoreboard;
    logic [11:0] threshold;
    logic [15:0] fraction;
    logic [5:0]  delay;
    logic [11:0] history [HIST_DEPTH];
    int unsigned sample_count;
    int unsigned arm_point;
    bit          armed;
    bit          found;
    logic [15:0] held_level;
    longint      last_sum;
    longint      sum_before;
    longint      sum_after;
    longint      cross_point;
    crossing_t   expected_crossings[$];
    int          errors;

    function void clear_waveform();
      foreach (history[i]) history[i] = '0;
      sample_count = 0;
      arm_point    = 0;
      armed        = 1'b0;
      found        = 1'b0;
      held_level   = '0;
      last_sum     = 0;
      sum_before   = 0;
      sum_after    = 0;
      cross_point  = 0;
    endfunction

    function void restore_defaults();
      threshold = cfd_pkg::THRESHOLD_RST;
      fraction  = cfd_pkg::FRACTION_RST;
      delay     = cfd_pkg::DELAY_RST;
      clear_waveform();
    endfunction

    function void set_register(logic [cfd_pkg::CFG_ADDR_W-1:0] addr, logic [15:0] data);
      case (addr)
        cfd_pkg::REG_THRESHOLD: threshold = data[11:0];
        cfd_pkg::REG_FRACTION:  fraction  = data;
        cfd_pkg::REG_DELAY:     delay     = data[5:0];
        default: ;
      endcase
    endfunction

    // Inverted, baseline-subtracted level at index k; zero before the waveform.
    function longint level_at(longint k);
      if (k < 0) return 0;
      return longint'(held_level) - 16 * longint'(history[k % HIST_DEPTH]);
    endfunction

    // One CFD sum at index k, and the search for its first positive value.
    function void window_step(longint k);
      longint pos;
      longint s;
      pos = k - (longint'(arm_point) - 1);
      if (found || pos < 0 || pos >= WINDOW_LEN) return;
      s = level_at(k - longint'(delay)) * 65536 - longint'(fraction) * level_at(k);
      if (pos >= 1 && s > 0) begin
        found       = 1'b1;
        sum_before  = last_sum;
        sum_after   = s;
        cross_point = k - 1;
      end
      last_sum = s;
    endfunction

    function void take_sample(logic [11:0] smp, logic [15:0] level, logic last);
      int unsigned n;
      longint      k;
      longint      num;
      longint      den;
      longint      t;
      crossing_t   res;
      n = sample_count;
      if (n == 0) held_level = level;
      history[n % HIST_DEPTH] = smp;

      // Arm on two consecutive samples under the threshold.
      if (!armed) begin
        if (n >= 1 && n - 1 < ARM_LIMIT && history[(n - 1) % HIST_DEPTH] < threshold &&
            smp < threshold) begin
          armed     = 1'b1;
          arm_point = n - 1;
          last_sum  = 0;
          for (k = longint'(n) - 2; k <= longint'(n); k++) window_step(k);
        end
      end else begin
        window_step(longint'(n));
      end
      if (sample_count < 65535) sample_count++;
      if (!last) return;

      // Final sample: status and interpolated crossing time.
      res.crossing_time = '0;
      if (!armed) begin
        res.status = cfd_pkg::ST_NO_ARM;
      end else if (!found) begin
        res.status = cfd_pkg::ST_NO_ZERO;
      end else begin
        num = -sum_before;
        den = sum_after - sum_before;
        if (den <= 0 || num < 0 || den * 100 < ONE_COUNT) begin
          res.status = cfd_pkg::ST_NO_ZERO;
        end else begin
          t = cross_point * 256 + (num * 256) / den;
          if (t < 0) t = 0;
          if (t > longint'(cfd_pkg::TIME_MAX)) t = longint'(cfd_pkg::TIME_MAX);
          res.crossing_time = t[cfd_pkg::TIME_W-1:0];
          res.status        = cfd_pkg::ST_OK;
        end
      end
      expected_crossings.push_back(res);
      clear_waveform();
    endfunction

    function void check_crossing(logic [cfd_pkg::TIME_W-1:0] t, logic [1:0] st);
      crossing_t want;
      if (expected_crossings.size() == 0) begin
        $display("%0t: result beat expected none, got crossing_time %0d status %0d",
                 $time, t, st);
        errors++;
        return;
      end
      want = expected_crossings.pop_front();
      if (t !== want.crossing_time) begin
        $display("%0t: crossing_time expected %0d, got %0d", $time, want.crossing_time, t);
        errors++;
      end
      if (st !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, st);
        errors++;
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [31:0]                    s_tdata;   // [11:0] sample, [27:12] baseline, [31:28] zero
  logic                           s_tlast;   // last_sample
  logic                           m_tvalid;
  logic                           m_tready;
  logic [23:0]                    m_tdata;   // [17:0] crossing_time, [23:18] zero
  logic [1:0]                     m_tuser;   // [1:0] status
  logic                           cfg_we;
  logic [cfd_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [15:0]                    cfg_wdata;

  crossing_scoreboard board;
  int                 burst_left;
  int                 gap_max;
  int                 stall_max;
  int                 ready_run;
  int                 quiet_cycles;
  int                 trace[$];

  constant_fraction_discriminator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Result side stalls in runs of random length.
  always @(negedge clk) begin
    if (ready_run > 0) begin
      ready_run--;
    end else if (m_tready && stall_max > 0) begin
      m_tready  = 1'b0;
      ready_run = $urandom_range(1, stall_max);
    end else begin
      m_tready  = 1'b1;
      ready_run = $urandom_range(0, 15);
    end
  end

  // Check every result beat.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.check_crossing(m_tdata[cfd_pkg::TIME_W-1:0], m_tuser);
    end
  end

  // Stop the run when no beat moves on either stream for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Send one sample beat; bursts of beats are separated by random gaps.
  task automatic send_sample(input logic [11:0] smp, input logic [15:0] level,
                             input logic last);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    s_tvalid = 1'b1;
    s_tdata  = {4'b0000, level, smp};
    s_tlast  = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    board.take_sample(smp, level, last);
  endtask

  task automatic hold_sender();
    @(negedge clk);
    s_tvalid   = 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_results();
    while (board.expected_crossings.size() != 0) @(posedge clk);
  endtask

  // Bring the block to idle before a register change.
  task automatic settle();
    hold_sender();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [cfd_pkg::CFG_ADDR_W-1:0] addr,
                                input logic [15:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    board.set_register(addr, data);
  endtask

  // Unused upper data bits carry junk so that masking is exercised.
  task automatic set_regs(input int thr, input int frac, input int dly);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_register(cfd_pkg::REG_THRESHOLD, {junk[15:12], thr[11:0]});
    write_register(cfd_pkg::REG_FRACTION, frac[15:0]);
    write_register(cfd_pkg::REG_DELAY, {junk[15:6], dly[5:0]});
  endtask

  // Send the samples in trace as one waveform.
  task automatic send_trace(input logic [15:0] level);
    int          i;
    int          v;
    logic [15:0] field;
    for (i = 0; i < trace.size(); i++) begin
      v     = trace[i];
      field = 16'($urandom);
      if (i == 0) field = level;
      send_sample(v[11:0], field, i == trace.size() - 1);
    end
  endtask

  // A waveform with a negative pulse of random shape around the threshold;
  // some are pure noise and some have a baseline unrelated to the signal.
  task automatic send_random_waveform(output int len);
    int          thr;
    int          top;
    int          bottom;
    int          onset;
    int          rise;
    int          fall;
    int          noise;
    int          jitter;
    int          shape;
    int          j;
    int          v;
    bit          junk_wave;
    logic [15:0] level;
    logic [15:0] field;
    thr = board.threshold;
    case ($urandom_range(0, 19)) inside
      0:       len = 1;
      1, 2:    len = $urandom_range(41, 120);
      default: len = $urandom_range(2, 40);
    endcase
    junk_wave = ($urandom_range(0, 6) == 0);
    if (thr >= 4095 || $urandom_range(0, 4) == 0) top = $urandom_range(0, 4095);
    else top = $urandom_range(thr + 1, 4095);
    bottom = (thr == 0) ? $urandom_range(0, 400) : $urandom_range(0, thr - 1);
    onset  = $urandom_range(0, len / 2);
    rise   = $urandom_range(1, 12);
    fall   = $urandom_range(1, 40);
    noise  = $urandom_range(0, 6);
    jitter = $urandom_range(0, 63);
    v      = top * 16 + jitter - 32;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    level = v[15:0];
    if ($urandom_range(0, 3) == 0) level = 16'($urandom);

    for (j = 0; j < len; j++) begin
      if (j < onset) shape = 0;
      else if (j - onset < rise) shape = (top - bottom) * (j - onset + 1) / rise;
      else if (j - onset < rise + fall) shape = (top - bottom) * (rise + fall - (j - onset)) / fall;
      else shape = 0;
      jitter = $urandom_range(0, 2 * noise);
      v = top - shape + jitter - noise;
      if (junk_wave) v = $urandom_range(0, 4095);
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      field = 16'($urandom);
      if (j == 0) field = level;
      send_sample(v[11:0], field, j == len - 1);
    end
  endtask

  initial begin
    int          seg;
    int          items;
    int          waves;
    int          len;
    int          i;
    int          v;
    logic [15:0] field;
    board = new();
    board.restore_defaults();
    clk          = 1'b0;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tlast      = 1'b0;
    m_tready     = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = cfd_pkg::REG_THRESHOLD;
    cfg_wdata    = '0;
    burst_left   = 0;
    gap_max      = 0;
    stall_max    = 0;
    ready_run    = 0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Tiny denominator, a lone sample at full scale, and all-zero levels.
    set_regs(4095, 1, 63);
    write_register(REG_UNUSED, 16'hFFFF);
    trace = '{100, 100, 101};
    send_trace(16'd1600);
    trace = '{4095};
    send_trace(16'hFFFF);
    trace = '{0, 0};
    send_trace(16'h0000);
    settle();

    // Arming at index 0 with a crossing time that would fall below zero.
    set_regs(4095, 65535, 11);
    trace = '{200, 200};
    send_trace(16'd1600);
    settle();

    // An ordinary pulse with no delay.
    set_regs(2600, 32768, 0);
    trace = '{3000, 2990, 2500, 1500, 800, 600, 900, 1500, 2200, 2700, 2950, 3000};
    send_trace(16'd48005);
    settle();

    // Long traces at the register defaults.
    set_regs(cfd_pkg::THRESHOLD_RST, cfd_pkg::FRACTION_RST, cfd_pkg::DELAY_RST);
    gap_max   = 3;
    stall_max = 4;
    // A low pair just past the search limit must not arm.
    for (i = 0; i < 402; i++) begin
      v     = (i >= 400) ? 0 : 4095;
      field = 16'($urandom);
      if (i == 0) field = 16'hFFF0;
      send_sample(v[11:0], field, i == 401);
    end
    // Arming on the last index that the search allows.
    for (i = 0; i < 410; i++) begin
      v     = (i >= 399 && i < 405) ? 1000 : 3500;
      field = 16'($urandom);
      if (i == 0) field = 16'd56000;
      send_sample(v[11:0], field, i == 409);
    end
    // Flat window with no positive sum; the steps after the window are ignored.
    for (i = 0; i < 602; i++) begin
      v     = (i < 600) ? 1000 : 1500;
      field = 16'($urandom);
      if (i == 0) field = 16'd16000;
      send_sample(v[11:0], field, i == 601);
    end

    // Random waveforms over several register settings and idle patterns.
    for (seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      case (seg)
        0:       set_regs(cfd_pkg::THRESHOLD_RST, cfd_pkg::FRACTION_RST,
                          cfd_pkg::DELAY_RST);
        1:       set_regs(4095, 0, 0);
        2:       set_regs(0, 65535, 63);
        3:       set_regs(2048, 65535, 0);
        default: set_regs($urandom_range(1000, 4000), $urandom_range(0, 65535),
                          $urandom_range(0, 63));
      endcase
      if (seg == 5) write_register(REG_UNUSED, 16'($urandom));
      gap_max   = (seg % 3 == 0) ? 0 : ((seg % 3 == 1) ? 3 : 20);
      stall_max = (seg % 4 == 0) ? 0 : ((seg % 4 == 1) ? 30 : 4);
      items     = 0;
      waves     = 0;
      while (items < RANDOM_ITEMS / SEGMENTS) begin
        if (waves % 12 == 5) begin
          // Let every pending result drain before the next waveform.
          hold_sender();
          wait_results();
        end
        send_random_waveform(len);
        items += len;
        waves++;
      end
    end

    hold_sender();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.expected_crossings.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
